[src/bmmd_pkg.sv]
`default_nettype none
package bmmd_pkg;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROM_PRESENT   = 1'b0;
  localparam logic CFG_ROM_SIZE_LOG2 = 1'b1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam int unsigned CPU_ADDR_W = 16;
  localparam int unsigned ROM_ADDR_W = 20;
  localparam int unsigned BANK_W     = 6;
  localparam int unsigned OFFSET_W   = 14;

  localparam logic [CPU_ADDR_W-1:0] RAM_BASE      = 16'hC000;
  localparam logic [CPU_ADDR_W-1:0] BANK0_REG     = 16'hFFFD;
  localparam logic [CPU_ADDR_W-1:0] BANK1_REG     = 16'hFFFE;
  localparam logic [CPU_ADDR_W-1:0] BANK2_REG     = 16'hFFFF;
  localparam logic [4:0]            MAX_ROM_LOG2  = 5'd20;
  localparam logic [7:0]            OPEN_BUS_BYTE = 8'hFF;

  // Reset contents of the bank registers
  localparam logic [BANK_W-1:0] BANK0_RESET = 6'd0;
  localparam logic [BANK_W-1:0] BANK1_RESET = 6'd1;
  localparam logic [BANK_W-1:0] BANK2_RESET = 6'd2;

  typedef enum logic [1:0] {
    SRC_RAM   = 2'd0,
    SRC_ROM   = 2'd1,
    SRC_OPEN  = 2'd2,
    SRC_WRITE = 2'd3
  } source_t;

  typedef struct packed {
    logic                  op;
    logic [CPU_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } access_t;

  typedef struct packed {
    source_t               source;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
  } result_t;

endpackage
`default_nettype wire

[src/bmmd_ram.sv]
`default_nettype none
module bmmd_ram import bmmd_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [7:0]               rdata,
  output logic                          clearing
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clear_addr;

  // Sweep zeros through every entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/banked_memory_map_decoder_unit.sv]
`default_nettype none
// Channel     Ports                               Direction  Transfer
// ----------  ----------------------------------  ---------  -----------------------------
// access      start, busy, access                 in         edge with start && !busy
// result      done, result                        out        a cycle with done high
// config      cfg_write, cfg_index, cfg_data      in         edge with cfg_write high
//
// Each accepted access gives its result in the next cycle, with done high for
// a single cycle; the work RAM's registered read sets that timing.
// A new access may be taken every cycle while busy is low, so up to one access per cycle.
// After reset, busy stays high while a sweep zeroes all RAM_DEPTH words (1024 at
// the default) of the work RAM; configuration writes are taken during that time.
// The receiver cannot stall: a result not taken in its done cycle is gone.
module banked_memory_map_decoder_unit import bmmd_pkg::*; #(
  parameter int unsigned RAM_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire access_t                access,
  output logic                        done,
  output result_t                     result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

  logic                  rom_present;
  logic [4:0]            rom_size_log2;
  logic [BANK_W-1:0]     slot_bank [3];

  logic                  accept;
  logic                  clearing;
  logic [RAM_AW-1:0]     ram_index;
  logic                  ram_we;
  logic [7:0]            ram_q;

  logic [1:0]            slot;
  logic [BANK_W-1:0]     bank;
  logic [ROM_ADDR_W-1:0] rom_raw;
  logic [4:0]            size_lg;
  logic [ROM_ADDR_W:0]   mask_wide;
  result_t               res_next;
  result_t               res;

  assign busy      = clearing;
  assign accept    = start && !busy;
  assign ram_index = access.addr[RAM_AW-1:0];
  assign ram_we    = accept && (access.op == OP_WRITE) && (access.addr >= RAM_BASE);

  bmmd_ram #(
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (ram_we),
    .waddr   (ram_index),
    .wdata   (access.wdata),
    .raddr   (ram_index),
    .rdata   (ram_q),
    .clearing(clearing)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_present   <= 1'b0;
      rom_size_log2 <= 5'd15;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROM_PRESENT:   rom_present   <= cfg_data[0];
        CFG_ROM_SIZE_LOG2: rom_size_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bank registers: load the low six bits of the byte on a mapper write
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bank[0] <= BANK0_RESET;
      slot_bank[1] <= BANK1_RESET;
      slot_bank[2] <= BANK2_RESET;
    end else if (accept && access.op == OP_WRITE) begin
      if (access.addr == BANK0_REG) begin
        slot_bank[0] <= access.wdata[BANK_W-1:0];
      end
      if (access.addr == BANK1_REG) begin
        slot_bank[1] <= access.wdata[BANK_W-1:0];
      end
      if (access.addr == BANK2_REG) begin
        slot_bank[2] <= access.wdata[BANK_W-1:0];
      end
    end
  end

  // ROM address: bank joined to the 14-bit slot offset; the first 1 KiB of
  // slot 0 always maps to bank 0, then mask to the ROM size
  always_comb begin
    slot = access.addr[CPU_ADDR_W-1:OFFSET_W];
    case (slot)
      2'd0:    bank = slot_bank[0];
      2'd1:    bank = slot_bank[1];
      default: bank = slot_bank[2];
    endcase
    if (slot == 2'd0 && access.addr[OFFSET_W-1:10] == '0) begin
      bank = '0;
    end
    rom_raw   = {bank, access.addr[OFFSET_W-1:0]};
    size_lg   = (rom_size_log2 > MAX_ROM_LOG2) ? MAX_ROM_LOG2 : rom_size_log2;
    mask_wide = ((ROM_ADDR_W+1)'(1) << size_lg) - (ROM_ADDR_W+1)'(1);

    res_next             = '0;
    if (access.op == OP_WRITE) begin
      res_next.source = SRC_WRITE;
    end else if (access.addr < RAM_BASE) begin
      if (rom_present) begin
        res_next.source      = SRC_ROM;
        res_next.rom_address = rom_raw & mask_wide[ROM_ADDR_W-1:0];
      end else begin
        res_next.source    = SRC_OPEN;
        res_next.read_data = OPEN_BUS_BYTE;
      end
    end else begin
      res_next.source = SRC_RAM;
    end
  end

  // Register the decoded result while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
    res <= res_next;
  end

  always_comb begin
    result = res;
    if (res.source == SRC_RAM) begin
      result.read_data = ram_q;
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted access");

  a_bank0_load: assert property (@(posedge clk) disable iff (rst)
    $past(accept && access.op == OP_WRITE && access.addr == BANK0_REG) && !$past(rst)
    |-> slot_bank[0] == $past(access.wdata[BANK_W-1:0]))
    else $error("slot 0 bank register not loaded");

  a_rom_needs_cart: assert property (@(posedge clk) disable iff (rst)
    done && result.source == SRC_ROM |-> rom_present)
    else $error("ROM fetch reported with no ROM attached");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !done)
    else $error("access taken during RAM clear");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import bmmd_pkg::*;

  // Cycle budget: the clearing sweep, ~2000 transfers with random gaps, plus
  // drains. Many times the slowest run.
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned RAM_WORDS       = 1024;
  localparam int unsigned MAX_REPORTED    = 10;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned NUM_PHASES      = 6;
  localparam logic [4:0]  ROM_LOG2_RESET  = 5'd15;
  // 0xFFFC is a mapper control address that only writes RAM here
  localparam logic [CPU_ADDR_W-1:0] CTRL_REG = 16'hFFFC;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  access_t                access;
  logic                   done;
  result_t                result;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  banked_memory_map_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .access    (access),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the decoder state, updated as transfers are accepted
  logic [BANK_W-1:0] bank_reg [3];
  logic [7:0]        ram_shadow [RAM_WORDS];
  logic              rom_attached;
  logic [4:0]        rom_log2;

  // Results still owed by the block, oldest first
  result_t pending_results [$];

  int unsigned cycle_count = 0;
  int unsigned failures    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_src [4]   = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTED) $display("[%0t] %s", $realtime, what);
  endtask

  function automatic void reset_shadow();
    bank_reg[0] = BANK0_RESET;
    bank_reg[1] = BANK1_RESET;
    bank_reg[2] = BANK2_RESET;
    foreach (ram_shadow[i]) ram_shadow[i] = 8'h00;
    rom_attached = 1'b0;
    rom_log2     = ROM_LOG2_RESET;
  endfunction

  // Decode one access against the shadow state and apply its side effects.
  function automatic result_t decode_access(input access_t a);
    result_t           r;
    logic [1:0]        slot;
    logic [9:0]        ram_idx;
    logic [19:0]       base;
    logic [20:0]       wide_mask;
    logic [4:0]        lg;
    r.source      = SRC_WRITE;
    r.rom_address = '0;
    r.read_data   = '0;
    ram_idx       = a.addr[9:0];
    if (a.op == OP_WRITE) begin
      // bank loads take the low six bits; the whole RAM range also stores the byte
      if (a.addr == BANK0_REG) bank_reg[0] = a.wdata[BANK_W-1:0];
      if (a.addr == BANK1_REG) bank_reg[1] = a.wdata[BANK_W-1:0];
      if (a.addr == BANK2_REG) bank_reg[2] = a.wdata[BANK_W-1:0];
      if (a.addr >= RAM_BASE) ram_shadow[ram_idx] = a.wdata;
    end else if (a.addr < RAM_BASE) begin
      slot = a.addr[15:14];
      base = {bank_reg[slot], {OFFSET_W{1'b0}}};
      // the first 1 KiB of slot 0 is pinned to bank 0
      if (slot == 2'd0 && a.addr[13:10] == 4'd0) base = '0;
      if (rom_attached) begin
        lg = (rom_log2 > MAX_ROM_LOG2) ? MAX_ROM_LOG2 : rom_log2;
        wide_mask     = (21'd1 << lg) - 21'd1;
        r.source      = SRC_ROM;
        r.rom_address = (base + 20'(a.addr[OFFSET_W-1:0])) & wide_mask[19:0];
      end else begin
        r.source    = SRC_OPEN;
        r.read_data = OPEN_BUS_BYTE;
      end
    end else begin
      r.source    = SRC_RAM;
      r.read_data = ram_shadow[ram_idx];
    end
    return r;
  endfunction

  // Result checker: every done cycle must match the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result src=%0d rom=%05h data=%02h",
                                 result.source, result.rom_address, result.read_data));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        n_src[want.source]++;
        if (result.source !== want.source || result.rom_address !== want.rom_address ||
            result.read_data !== want.read_data)
          report_failure($sformatf(
            "mismatch: expected src=%0d rom=%05h data=%02h, got src=%0d rom=%05h data=%02h",
            want.source, want.rom_address, want.read_data,
            result.source, result.rom_address, result.read_data));
      end
    end
  end

  // Present one access and hold it until the block takes it.
  // Start is left high so a following transfer can go out back to back.
  task automatic send_access(input access_t item);
    @(negedge clk);
    start  = 1'b1;
    access = item;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(decode_access(item));
    n_sent++;
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start  = 1'b0;
    access = access_t'($urandom);
  endtask

  // Insert a geometric gap: each cycle idles with the given percentage.
  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(0, 99) < pct) idle_cycle();
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic wait_for_results();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    if (idx == CFG_ROM_PRESENT) rom_attached = data[0];
    else rom_log2 = data;
    n_cfg++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic access_t make_access(input logic op, input logic [15:0] addr,
                                          input logic [7:0] wdata);
    access_t a;
    a.op    = op;
    a.addr  = addr;
    a.wdata = wdata;
    return a;
  endfunction

  // Mostly well-formed traffic: slot reads, bank loads, control writes, RAM writes
  // and reads over a small hot set of words, and some fully random accesses.
  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    logic [9:0]  ram_idx;
    pick    = $urandom_range(0, 99);
    a       = make_access(OP_READ, 16'($urandom), 8'($urandom));
    ram_idx = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
    if (pick < 40) begin
      a.addr = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'h07FF))
                                           : 16'($urandom_range(0, 16'hBFFF));
    end else if (pick < 60) begin
      a.addr = {2'b11, 4'($urandom), ram_idx};
    end else if (pick < 75) begin
      a.op   = OP_WRITE;
      a.addr = 16'($urandom_range(BANK0_REG, BANK2_REG));
    end else if (pick < 80) begin
      a.op   = OP_WRITE;
      a.addr = CTRL_REG;
    end else if (pick < 92) begin
      a.op   = OP_WRITE;
      a.addr = {2'b11, 4'($urandom), ram_idx};
    end else begin
      a.op = 1'($urandom);
    end
    return a;
  endfunction

  // Out of reset: no ROM, so slot reads float and RAM reads see the cleared RAM.
  task automatic test_open_bus();
    send_access(make_access(OP_READ, 16'h0000, 8'h00));
    send_access(make_access(OP_READ, 16'hBFFF, 8'hFF));
    send_access(make_access(OP_READ, RAM_BASE, 8'h00));
    send_access(make_access(OP_READ, BANK2_REG, 8'h00));
  endtask

  // Reset banks, the pinned first 1 KiB, bank loads, the control address,
  // and a write below RAM that must change nothing.
  task automatic test_bank_switching();
    write_cfg(CFG_ROM_PRESENT, 5'b11111);
    write_cfg(CFG_ROM_SIZE_LOG2, 5'd20);
    send_access(make_access(OP_READ, 16'h0000, 8'h00));
    send_access(make_access(OP_READ, 16'h03FF, 8'h00));
    send_access(make_access(OP_READ, 16'h0400, 8'h00));
    send_access(make_access(OP_READ, 16'h4000, 8'h00));
    send_access(make_access(OP_READ, 16'h8000, 8'h00));
    send_access(make_access(OP_WRITE, BANK0_REG, 8'hFF));
    send_access(make_access(OP_WRITE, BANK1_REG, 8'hAA));
    send_access(make_access(OP_WRITE, BANK2_REG, 8'h55));
    send_access(make_access(OP_WRITE, CTRL_REG, 8'h12));
    send_access(make_access(OP_WRITE, 16'h3FFF, 8'hFF));
    send_access(make_access(OP_READ, 16'h0100, 8'h00));
    send_access(make_access(OP_READ, 16'h0400, 8'h00));
    send_access(make_access(OP_READ, 16'h7FFF, 8'h00));
    send_access(make_access(OP_READ, 16'hBFFF, 8'h00));
  endtask

  // RAM mirroring across 0xC000-0xFFFF, including bytes left by register writes.
  task automatic test_ram_mirror();
    send_access(make_access(OP_WRITE, RAM_BASE, 8'hA5));
    send_access(make_access(OP_READ, 16'hDC00, 8'h00));
    send_access(make_access(OP_READ, 16'hC3FC, 8'h00));
    send_access(make_access(OP_READ, 16'hC3FF, 8'h00));
  endtask

  // Mask extremes: saturation above 20, zero maps everything to 0, and below 10.
  task automatic test_rom_mask();
    logic [4:0] sizes [3] = '{5'd31, 5'd0, 5'd9};
    foreach (sizes[i]) begin
      write_cfg(CFG_ROM_SIZE_LOG2, sizes[i]);
      send_access(make_access(OP_READ, 16'hBFFF, 8'h00));
    end
  endtask

  // Random traffic in phases with different sender idling and ROM settings.
  task automatic test_random_traffic();
    int unsigned idle_pct [3] = '{0, 82, 11};
    logic [4:0]  phase_size [NUM_PHASES] = '{5'd20, 5'd10, 5'd15, 5'd31, 5'd0, 5'd19};
    logic        phase_rom [NUM_PHASES]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    logic [4:0]  size_now;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      size_now = (ph == 4) ? 5'($urandom) : phase_size[ph];
      write_cfg(CFG_ROM_PRESENT, {4'($urandom), phase_rom[ph]});
      write_cfg(CFG_ROM_SIZE_LOG2, size_now);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sender_gap(idle_pct[ph % 3]);
        // now and then hold off entirely until the block has caught up
        if ($urandom_range(0, 199) == 0) wait_for_results();
        send_access(random_access());
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    access    = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_ROM_PRESENT;
    cfg_data  = '0;
    reset_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_open_bus();
    test_bank_switching();
    test_ram_mirror();
    test_rom_mask();
    test_random_traffic();

    wait_for_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d accesses in %0d configurations: RAM %0d, ROM %0d, open bus %0d, writes %0d",
             n_sent, n_cfg, n_src[SRC_RAM], n_src[SRC_ROM], n_src[SRC_OPEN], n_src[SRC_WRITE]);
    $display("Sender idling 0/82/11 percent, %0d results checked, %0d failures",
             n_checked, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
